// File: rtl/swvf_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window vertex finder package
// Shared sizes, register indexes and the datapath command set.
// ----------------------------------------------------------------------------
package swvf_pkg;

   // Storage and field sizes.
   localparam int MAX_HITS  = 256;
   localparam int ADDR_W    = $clog2(MAX_HITS);
   localparam int CNT_W     = $clog2(MAX_HITS + 1);
   localparam int Z_W       = 18;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;
   // Window edges reach past the hit range by up to the offset, size and step.
   localparam int POS_W     = Z_W + 3;
   // Signed sum of up to MAX_HITS hits, and its magnitude.
   localparam int SUM_W     = Z_W + ADDR_W + 1;
   localparam int MAG_W     = SUM_W - 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_OFFSET = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [CFG_W-1:0] RESET_WINDOW_SIZE  = 16'd500;
   localparam logic [CFG_W-1:0] RESET_WINDOW_STEP  = 16'd250;
   localparam logic [CFG_W-1:0] RESET_START_OFFSET = 16'd100;

   // Commands from the controller to the datapath.
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_SCAN_INIT,
      DP_WIN_START,
      DP_WIN_EVAL,
      DP_WIN_END,
      DP_POST_INIT,
      DP_POST_SET2,
      DP_POST_EVAL,
      DP_MEAN_INIT,
      DP_MEAN_EVAL,
      DP_DIV_START,
      DP_OUT_EMPTY,
      DP_OUT_RESULT
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more_windows;
      logic elem_avail;
      logic win_break;
      logic post_stop;
      logic mean_stop;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/sliding_window_vertex_finder.sv
// ----------------------------------------------------------------------------
// Sliding window vertex finder
// Collects an event's hit z positions and returns the mean of the hits in
// the busiest window, widened toward the busier neighbor.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Payload
//   req_*     in         req_valid/stall     z_value, last_hit, no_hits
//   rsp_*     out        rsp_valid/stall     vertex_z, reconstructed
//   csr_*     in         csr_write           csr_index, csr_data
//
// A hit request stores its hit while the hit store has room. An ending
// request starts the scan: the windows, the side counts and the mean sum
// each read the stored hits one at a time through the single hit store
// read port, and the bit-serial divider then forms the mean. An empty
// event request returns an empty result. Reset is synchronous; no clearing
// pass is needed. A stalled result holds the finder before it can hand off
// its next result.
module sliding_window_vertex_finder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [swvf_pkg::Z_W-1:0]    req_z_value,
   input  logic                               req_last_hit,
   input  logic                               req_no_hits,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [swvf_pkg::Z_W-1:0]    rsp_vertex_z,
   output logic                               rsp_reconstructed,
   input  logic                               csr_write,
   input  logic [swvf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swvf_pkg::CFG_W-1:0]         csr_data
);

   swvf_pkg::dp_cmd_type    cmd;
   swvf_pkg::dp_status_type status;

   swvf_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_hit (req_last_hit),
      .req_no_hits  (req_no_hits),
      .req_stall    (req_stall),
      .status       (status),
      .cmd          (cmd)
   );

   swvf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_z_value       (req_z_value),
      .req_no_hits       (req_no_hits),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vertex_z      (rsp_vertex_z),
      .rsp_reconstructed (rsp_reconstructed)
   );

endmodule

// File: rtl/swvf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swvf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/swvf_div.sv
// ----------------------------------------------------------------------------
// Mean divider
// Restoring signed-by-unsigned division, one quotient bit per cycle,
// rounding toward zero.
// ----------------------------------------------------------------------------
module swvf_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [swvf_pkg::SUM_W-1:0] dividend,
   input  logic [swvf_pkg::CNT_W-1:0]        divisor,
   output logic                             done,
   output logic signed [swvf_pkg::Z_W-1:0]   quotient
);

   localparam int BIT_W = $clog2(swvf_pkg::MAG_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          neg_ff, neg_in;
   logic [BIT_W-1:0]              bits_ff, bits_in;
   logic [swvf_pkg::MAG_W-1:0]    quo_ff, quo_in;
   logic [swvf_pkg::CNT_W:0]      rem_ff, rem_in;
   logic [swvf_pkg::CNT_W-1:0]    div_ff, div_in;
   logic [swvf_pkg::SUM_W-1:0]    magnitude;
   logic [swvf_pkg::CNT_W:0]      shifted;
   logic [swvf_pkg::MAG_W-1:0]    result;

   assign magnitude = dividend[swvf_pkg::SUM_W-1] ? -dividend : dividend;
   assign shifted   = {rem_ff[swvf_pkg::CNT_W-1:0], quo_ff[swvf_pkg::MAG_W-1]};

   // One restoring step per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in  = dividend[swvf_pkg::SUM_W-1];
         bits_in = BIT_W'(swvf_pkg::MAG_W);
         quo_in  = magnitude[swvf_pkg::MAG_W-1:0];
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[swvf_pkg::MAG_W-2:0], 1'b0};
         if (shifted >= {1'b0, div_ff}) begin
            rem_in    = shifted - {1'b0, div_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = shifted;
         end
         bits_in = bits_ff - 1'b1;
         if (bits_ff == BIT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign result   = neg_ff ? -quo_ff : quo_ff;
   assign done     = done_ff;
   assign quotient = result[swvf_pkg::Z_W-1:0];

endmodule

// File: rtl/swvf_ctrl.sv
// ----------------------------------------------------------------------------
// Vertex finder controller
// Sequences hit loading, the window scan, the side counts, the mean sum,
// the division and the result hand-off.
// ----------------------------------------------------------------------------
module swvf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last_hit,
   input  logic                    req_no_hits,
   output logic                    req_stall,
   input  swvf_pkg::dp_status_type status,
   output swvf_pkg::dp_cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_EMPTY = 13'b0000000000010,
      ST_WINIT = 13'b0000000000100,
      ST_WCHK  = 13'b0000000001000,
      ST_WRD   = 13'b0000000010000,
      ST_WEV   = 13'b0000000100000,
      ST_PSET1 = 13'b0000001000000,
      ST_PSET2 = 13'b0000010000000,
      ST_PRD   = 13'b0000100000000,
      ST_PEV   = 13'b0001000000000,
      ST_MSET  = 13'b0010000000000,
      ST_MRD   = 13'b0100000000000,
      ST_MDIV  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      started_ff, started_in;

   assign req_stall = (state_ff != ST_IDLE);

   // Next state and command.
   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      cmd        = swvf_pkg::DP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd = swvf_pkg::DP_LOAD;
               if (req_no_hits) begin
                  state_in = ST_EMPTY;
               end else if (req_last_hit) begin
                  state_in = ST_WINIT;
               end
            end
         end
         ST_EMPTY: begin
            if (status.out_free) begin
               cmd      = swvf_pkg::DP_OUT_EMPTY;
               state_in = ST_IDLE;
            end
         end
         ST_WINIT: begin
            cmd      = swvf_pkg::DP_SCAN_INIT;
            state_in = ST_WCHK;
         end
         ST_WCHK: begin
            if (status.more_windows) begin
               cmd      = swvf_pkg::DP_WIN_START;
               state_in = ST_WRD;
            end else begin
               state_in = ST_PSET1;
            end
         end
         ST_WRD: begin
            if (status.elem_avail) begin
               state_in = ST_WEV;
            end else begin
               cmd      = swvf_pkg::DP_WIN_END;
               state_in = ST_WCHK;
            end
         end
         ST_WEV: begin
            if (status.win_break) begin
               cmd      = swvf_pkg::DP_WIN_END;
               state_in = ST_WCHK;
            end else begin
               cmd      = swvf_pkg::DP_WIN_EVAL;
               state_in = ST_WRD;
            end
         end
         ST_PSET1: begin
            cmd      = swvf_pkg::DP_POST_INIT;
            state_in = ST_PSET2;
         end
         ST_PSET2: begin
            cmd      = swvf_pkg::DP_POST_SET2;
            state_in = ST_PRD;
         end
         ST_PRD: begin
            state_in = status.elem_avail ? ST_PEV : ST_MSET;
         end
         ST_PEV: begin
            if (status.post_stop) begin
               state_in = ST_MSET;
            end else begin
               cmd      = swvf_pkg::DP_POST_EVAL;
               state_in = ST_PRD;
            end
         end
         ST_MSET: begin
            cmd      = swvf_pkg::DP_MEAN_INIT;
            state_in = ST_MRD;
         end
         ST_MRD: begin
            if (status.elem_avail) begin
               state_in = ST_MDIV;
               started_in = 1'b0;
            end else begin
               cmd        = swvf_pkg::DP_DIV_START;
               started_in = 1'b1;
               state_in   = ST_MDIV;
            end
         end
         ST_MDIV: begin
            // Before the division starts, evaluate a mean element or start it.
            if (!started_ff) begin
               if (status.mean_stop) begin
                  cmd        = swvf_pkg::DP_DIV_START;
                  started_in = 1'b1;
               end else begin
                  cmd      = swvf_pkg::DP_MEAN_EVAL;
                  state_in = ST_MRD;
               end
            end else if (status.div_done && status.out_free) begin
               cmd      = swvf_pkg::DP_OUT_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         started_ff <= started_in;
      end
   end

endmodule

// File: rtl/swvf_dp.sv
// ----------------------------------------------------------------------------
// Vertex finder datapath
// Configuration registers, hit store, scan registers, divider and the
// result register.
// ----------------------------------------------------------------------------
module swvf_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [swvf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [swvf_pkg::CFG_W-1:0]           csr_data,
   input  logic signed [swvf_pkg::Z_W-1:0]      req_z_value,
   input  logic                                 req_no_hits,
   input  swvf_pkg::dp_cmd_type                 cmd,
   output swvf_pkg::dp_status_type              status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swvf_pkg::Z_W-1:0]      rsp_vertex_z,
   output logic                                 rsp_reconstructed
);

   localparam int PW = swvf_pkg::POS_W;
   localparam int CW = swvf_pkg::CNT_W;

   // Configuration registers.
   logic [swvf_pkg::CFG_W-1:0] size_ff, step_ff, offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= swvf_pkg::RESET_WINDOW_SIZE;
         step_ff   <= swvf_pkg::RESET_WINDOW_STEP;
         offset_ff <= swvf_pkg::RESET_START_OFFSET;
      end else if (csr_write) begin
         priority case (csr_index)
            swvf_pkg::REG_WINDOW_SIZE:  size_ff   <= csr_data;
            swvf_pkg::REG_WINDOW_STEP:  step_ff   <= csr_data;
            swvf_pkg::REG_START_OFFSET: offset_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Scan state.
   logic [CW-1:0]                 count_ff, count_in;
   logic signed [swvf_pkg::Z_W-1:0] first_ff, first_in, last_ff, last_in;
   logic [CW-1:0]                 k_ff, k_in, kstart_ff, kstart_in;
   logic signed [PW-1:0]          lo_ff, lo_in, hi_ff, hi_in, plo_ff, plo_in;
   logic signed [PW-1:0]          phi_ff, phi_in, blo_ff, blo_in, ahi_ff, ahi_in;
   logic signed [PW-1:0]          mlo_ff, mlo_in, mhi_ff, mhi_in;
   logic [CW-1:0]                 c_ff, c_in, cmax_ff, cmax_in;
   logic [CW-1:0]                 before_ff, before_in, after_ff, after_in;
   logic [CW-1:0]                 n_ff, n_in;
   logic signed [swvf_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                          first_hit_ff, first_hit_in;
   logic                          flag_ff, flag_in, adj_ff, adj_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [swvf_pkg::Z_W-1:0] vz_ff, vz_in;
   logic                          rec_ff, rec_in;

   logic                          store_en;
   logic signed [swvf_pkg::Z_W-1:0] rd_data;
   logic signed [PW-1:0]          v;
   logic signed [PW-1:0]          size_x, step_x;
   logic                          div_done;
   logic signed [swvf_pkg::Z_W-1:0] div_q;

   assign store_en = (cmd == swvf_pkg::DP_LOAD) && !req_no_hits
                     && (count_ff != CW'(swvf_pkg::MAX_HITS));
   assign v        = PW'(rd_data);
   assign size_x   = PW'({1'b0, size_ff});
   assign step_x   = PW'({1'b0, step_ff});

   swvf_ram #(
      .WIDTH(swvf_pkg::Z_W),
      .DEPTH(swvf_pkg::MAX_HITS)
   ) u_hit_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[swvf_pkg::ADDR_W-1:0]),
      .wr_data (req_z_value),
      .rd_addr (k_ff[swvf_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   swvf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd == swvf_pkg::DP_DIV_START),
      .dividend (sum_ff),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Status back to the controller.
   always_comb begin
      status.more_windows = PW'(last_ff) > lo_ff;
      status.elem_avail   = k_ff < count_ff;
      status.win_break    = v > hi_ff;
      status.post_stop    = v >= ahi_ff;
      status.mean_stop    = v > mhi_ff;
      status.div_done     = div_done;
      status.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // Command execution.
   always_comb begin
      count_in     = count_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      kstart_in    = kstart_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      blo_in       = blo_ff;
      ahi_in       = ahi_ff;
      mlo_in       = mlo_ff;
      mhi_in       = mhi_ff;
      c_in         = c_ff;
      cmax_in      = cmax_ff;
      before_in    = before_ff;
      after_in     = after_ff;
      n_in         = n_ff;
      sum_in       = sum_ff;
      first_hit_in = first_hit_ff;
      flag_in      = flag_ff;
      adj_in       = adj_ff;
      vz_in        = vz_ff;
      rec_in       = rec_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cmd)
         swvf_pkg::DP_NONE: begin
         end
         swvf_pkg::DP_LOAD: begin
            if (req_no_hits) begin
               count_in = '0;
            end else if (store_en) begin
               if (count_ff == '0) begin
                  first_in = req_z_value;
               end
               last_in  = req_z_value;
               count_in = count_ff + 1'b1;
            end
         end
         swvf_pkg::DP_SCAN_INIT: begin
            lo_in     = PW'(first_ff) - PW'({1'b0, offset_ff});
            plo_in    = PW'(first_ff) - PW'({1'b0, offset_ff});
            cmax_in   = '0;
            flag_in   = 1'b1;
            adj_in    = 1'b0;
            kstart_in = '0;
         end
         swvf_pkg::DP_WIN_START: begin
            hi_in        = lo_ff + size_x;
            k_in         = kstart_ff;
            c_in         = '0;
            first_hit_in = 1'b1;
         end
         swvf_pkg::DP_WIN_EVAL: begin
            if (v >= lo_ff) begin
               if (first_hit_ff) begin
                  kstart_in    = k_ff;
                  first_hit_in = 1'b0;
               end
               c_in = c_ff + 1'b1;
            end
            k_in = k_ff + 1'b1;
         end
         swvf_pkg::DP_WIN_END: begin
            // A new maximum, or a tie with a window that is not the next one.
            if (c_ff > cmax_ff) begin
               cmax_in = c_ff;
               flag_in = 1'b1;
               plo_in  = lo_ff;
               adj_in  = 1'b1;
            end else begin
               if ((c_ff == cmax_ff) && !adj_ff) begin
                  flag_in = 1'b0;
               end
               adj_in = 1'b0;
            end
            lo_in = lo_ff + step_x;
         end
         swvf_pkg::DP_POST_INIT: begin
            phi_in    = plo_ff + size_x;
            blo_in    = plo_ff - step_x;
            k_in      = '0;
            before_in = '0;
            after_in  = '0;
         end
         swvf_pkg::DP_POST_SET2: begin
            ahi_in = phi_ff + step_x;
         end
         swvf_pkg::DP_POST_EVAL: begin
            if ((v >= blo_ff) && (v <= plo_ff)) begin
               before_in = before_ff + 1'b1;
            end
            if (v >= phi_ff) begin
               after_in = after_ff + 1'b1;
            end
            k_in = k_ff + 1'b1;
         end
         swvf_pkg::DP_MEAN_INIT: begin
            // Widen toward the busier side, the lower one on a tie.
            if (before_ff >= after_ff) begin
               mlo_in = blo_ff;
               mhi_in = phi_ff;
            end else begin
               mlo_in = plo_ff;
               mhi_in = ahi_ff;
            end
            k_in   = '0;
            n_in   = '0;
            sum_in = '0;
         end
         swvf_pkg::DP_MEAN_EVAL: begin
            if (v >= mlo_ff) begin
               sum_in = sum_ff + swvf_pkg::SUM_W'(rd_data);
               n_in   = n_ff + 1'b1;
            end
            k_in = k_ff + 1'b1;
         end
         swvf_pkg::DP_DIV_START: begin
         end
         swvf_pkg::DP_OUT_EMPTY: begin
            vz_in        = '0;
            rec_in       = 1'b0;
            rsp_valid_in = 1'b1;
         end
         swvf_pkg::DP_OUT_RESULT: begin
            if (n_ff == '0) begin
               vz_in  = '0;
               rec_in = 1'b0;
            end else begin
               vz_in  = div_q;
               rec_in = flag_ff;
            end
            count_in     = '0;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff     <= first_in;
      last_ff      <= last_in;
      k_ff         <= k_in;
      kstart_ff    <= kstart_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      blo_ff       <= blo_in;
      ahi_ff       <= ahi_in;
      mlo_ff       <= mlo_in;
      mhi_ff       <= mhi_in;
      c_ff         <= c_in;
      cmax_ff      <= cmax_in;
      before_ff    <= before_in;
      after_ff     <= after_in;
      n_ff         <= n_in;
      sum_ff       <= sum_in;
      first_hit_ff <= first_hit_in;
      flag_ff      <= flag_in;
      adj_ff       <= adj_in;
      vz_ff        <= vz_in;
      rec_ff       <= rec_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vertex_z      = vz_ff;
   assign rsp_reconstructed = rec_ff;

endmodule
